// ----- hw/rtl/pqgs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the packet queue grant segmenter.
// No dependencies; used by the datapath, the controller and the top level.
package pqgs_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MAX_RESULTS     = 64;
    localparam int RES_AW          = $clog2(MAX_RESULTS);
    localparam int RES_CW          = $clog2(MAX_RESULTS + 1);

    localparam logic [23:0] CAPACITY_RESET = 24'd1000000;
    localparam logic [15:0] MARGIN_RESET   = 16'd0;

    // configuration register indexes
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_MARGIN   = 2'd1;

    // input commands
    localparam logic [1:0] CMD_GEN   = 2'd0;
    localparam logic [1:0] CMD_GRANT = 2'd1;
    localparam logic [1:0] CMD_POP   = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_PKT    = 2'd0;
    localparam logic [1:0] KIND_GEN    = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;
    localparam logic [1:0] KIND_TICKED = 2'd3;

    // datapath operations issued by the controller
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD        = 4'd1;
    localparam logic [OP_W-1:0] OP_DIV_START   = 4'd2;
    localparam logic [OP_W-1:0] OP_GEN_SETUP   = 4'd3;
    localparam logic [OP_W-1:0] OP_GEN_FULL    = 4'd4;
    localparam logic [OP_W-1:0] OP_GEN_LAST    = 4'd5;
    localparam logic [OP_W-1:0] OP_GEN_RESULT  = 4'd6;
    localparam logic [OP_W-1:0] OP_HEAD_READ   = 4'd7;
    localparam logic [OP_W-1:0] OP_GRANT_EVAL  = 4'd8;
    localparam logic [OP_W-1:0] OP_GRANT_END   = 4'd9;
    localparam logic [OP_W-1:0] OP_POP_EVAL    = 4'd10;
    localparam logic [OP_W-1:0] OP_NONE_RESULT = 4'd11;
    localparam logic [OP_W-1:0] OP_TICK        = 4'd12;
    localparam logic [OP_W-1:0] OP_OLDEST      = 4'd13;
    localparam logic [OP_W-1:0] OP_BUF_READ    = 4'd14;
    localparam logic [OP_W-1:0] OP_OUT_LOAD    = 4'd15;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] size;
        logic [31:0] stamp;
        logic [15:0] delay;
        logic [15:0] jitter;
        logic        fflag;
        logic [7:0]  fcount;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [15:0] bits;
        logic        fflag;
        logic [7:0]  fcount;
        logic [31:0] stamp;
        logic [15:0] delay;
        logic [15:0] jitter;
        logic [23:0] moved;
    } res_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       div_done;
        logic       gen_ok;
        logic       full_more;
        logic       app_ok;
        logic       grant_go;
        logic       grant_stop;
        logic       cnt_nz;
        logic       out_free;
        logic       em_last;
    } st_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int RES_W   = $bits(res_t);

    function automatic logic [7:0] bump(input logic [7:0] c);
        return (c == 8'hFF) ? 8'hFF : c + 8'd1;
    endfunction

endpackage

// ----- hw/rtl/pqgs_ram.sv -----
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pqgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/pqgs_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module pqgs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [23:0] quot,
    output logic [15:0] rem
);

    logic [23:0] q_reg, q_next;
    logic [15:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic        ge;

    always_comb
    begin
        trial     = {r_reg, q_reg[23]};
        ge        = trial >= {1'b0, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 5'd24;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so 16 bits hold it
            r_next   = ge ? 16'(trial - {1'b0, d_reg}) : trial[15:0];
            q_next   = {q_reg[22:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ----- hw/rtl/pqgs_datapath.sv -----
`timescale 1ns / 1ps
// Queue datapath: queue state, entry store, result buffer, divider, output register.
// Depends on pqgs_pkg, pqgs_ram, pqgs_div.
module pqgs_datapath #(
    parameter int QUEUE_DEPTH = pqgs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pqgs_pkg::ctl_t   ctl,
    output pqgs_pkg::st_t    st,
    input  logic [1:0]       command,
    input  logic [23:0]      bit_amount,
    input  logic [15:0]      packet_size,
    input  logic [31:0]      time_now,
    input  logic [15:0]      backhaul_delay,
    input  logic [15:0]      backhaul_jitter,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [31:0]      packet_id,
    output logic [15:0]      packet_bits,
    output logic             fragment_flag,
    output logic [7:0]       fragment_count,
    output logic [31:0]      arrival_time,
    output logic [15:0]      delay_out,
    output logic [15:0]      jitter_out,
    output logic [23:0]      moved_bits,
    output logic [23:0]      occupancy,
    output logic [31:0]      oldest_time,
    output logic             last,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [23:0]      cfg_wdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_C = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam int RAW = pqgs_pkg::RES_AW;
    localparam int RCW = pqgs_pkg::RES_CW;
    localparam logic [RCW-1:0] MAX_N = RCW'(pqgs_pkg::MAX_RESULTS);

    // control state
    logic [AW-1:0]  head_reg, head_next;
    logic [AW:0]    count_reg, count_next;
    logic [23:0]    queued_reg, queued_next;
    logic [31:0]    next_id_reg, next_id_next;
    logic [31:0]    cur_time_reg, cur_time_next;
    logic [23:0]    cap_reg, cap_next;
    logic [15:0]    margin_reg, margin_next;
    logic [RCW-1:0] n_reg, n_next;
    logic [RCW-1:0] k_reg, k_next;
    logic           out_valid_reg, out_valid_next;

    // payload
    logic [1:0]  cmd_reg, cmd_next;
    logic [23:0] amt_reg, amt_next;
    logic [15:0] psize_reg, psize_next;
    logic [31:0] tnow_reg, tnow_next;
    logic [15:0] dly_reg, dly_next;
    logic [15:0] jit_reg, jit_next;
    logic [23:0] budget_reg, budget_next;
    logic [23:0] moved_reg, moved_next;
    logic [23:0] full_reg, full_next;
    logic [23:0] pkts_reg, pkts_next;
    logic [15:0] lsize_reg, lsize_next;
    logic [23:0] i_reg, i_next;
    logic [31:0] oldest_reg, oldest_next;
    pqgs_pkg::res_t out_res_reg, out_res_next;
    logic [23:0] out_occ_reg, out_occ_next;
    logic [31:0] out_old_reg, out_old_next;
    logic        out_last_reg, out_last_next;

    // memories
    logic                        ent_we, ent_re;
    logic [AW-1:0]               ent_waddr;
    pqgs_pkg::entry_t            ent_wdata, ent_rd;
    logic [pqgs_pkg::ENTRY_W-1:0] ent_rdata;
    logic                        buf_we, buf_re;
    pqgs_pkg::res_t              res, buf_rd;
    logic [pqgs_pkg::RES_W-1:0]  buf_rdata;

    // divider
    logic        div_start, div_done;
    logic [23:0] div_q;
    logic [15:0] div_r;

    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;
    logic [AW-1:0] head_inc;
    logic          not_full;
    logic          app_ok_full, app_ok_last;
    logic [7:0]    cnt_bumped;
    logic          whole;
    logic [23:0]   budget_left;

    pqgs_ram #(.WIDTH(pqgs_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_entries (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (head_reg),
        .rdata (ent_rdata)
    );

    pqgs_ram #(.WIDTH(pqgs_pkg::RES_W), .DEPTH(pqgs_pkg::MAX_RESULTS)) u_results (
        .clk   (clk),
        .we    (buf_we),
        .waddr (n_reg[RAW-1:0]),
        .wdata (res),
        .re    (buf_re),
        .raddr (k_reg[RAW-1:0]),
        .rdata (buf_rdata)
    );

    pqgs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (amt_reg),
        .divisor  (psize_reg),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    assign ent_rd = pqgs_pkg::entry_t'(ent_rdata);
    assign buf_rd = pqgs_pkg::res_t'(buf_rdata);

    always_comb
    begin
        tail_sum    = {1'b0, head_reg} + count_reg;
        tail        = (tail_sum >= DEPTH_C) ? AW'(tail_sum - DEPTH_C) : tail_sum[AW-1:0];
        head_inc    = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
        not_full    = count_reg < DEPTH_C;
        app_ok_full = not_full && ({1'b0, queued_reg} + {9'd0, psize_reg} <= {1'b0, cap_reg});
        app_ok_last = not_full && ({1'b0, queued_reg} + {9'd0, lsize_reg} <= {1'b0, cap_reg});
        cnt_bumped  = pqgs_pkg::bump(ent_rd.fcount);
        whole       = budget_reg >= {8'd0, ent_rd.size};
        budget_left = budget_reg - {8'd0, ent_rd.size};
    end

    always_comb
    begin
        st.cmd        = cmd_reg;
        st.div_done   = div_done;
        st.gen_ok     = (psize_reg != '0) && (amt_reg != '0) && (queued_reg < cap_reg);
        st.full_more  = i_reg < full_reg;
        st.app_ok     = app_ok_full;
        st.grant_go   = (budget_reg != '0) && (count_reg != '0) && (n_reg < MAX_N);
        st.grant_stop = whole ? (budget_left <= {8'd0, margin_reg}) : 1'b1;
        st.cnt_nz     = count_reg != '0;
        st.out_free   = !out_valid_reg || out_ready;
        st.em_last    = (k_reg + RCW'(1)) == n_reg;
    end

    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        queued_next   = queued_reg;
        next_id_next  = next_id_reg;
        cur_time_next = cur_time_reg;
        cap_next      = cap_reg;
        margin_next   = margin_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        cmd_next      = cmd_reg;
        amt_next      = amt_reg;
        psize_next    = psize_reg;
        tnow_next     = tnow_reg;
        dly_next      = dly_reg;
        jit_next      = jit_reg;
        budget_next   = budget_reg;
        moved_next    = moved_reg;
        full_next     = full_reg;
        pkts_next     = pkts_reg;
        lsize_next    = lsize_reg;
        i_next        = i_reg;
        oldest_next   = oldest_reg;
        out_res_next  = out_res_reg;
        out_occ_next  = out_occ_reg;
        out_old_next  = out_old_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        ent_we           = 1'b0;
        ent_re           = 1'b0;
        ent_waddr        = tail;
        ent_wdata.id     = next_id_reg + {8'd0, i_reg};
        ent_wdata.size   = psize_reg;
        ent_wdata.stamp  = tnow_reg;
        ent_wdata.delay  = dly_reg;
        ent_wdata.jitter = jit_reg;
        ent_wdata.fflag  = 1'b0;
        ent_wdata.fcount = '0;
        buf_we           = 1'b0;
        buf_re           = 1'b0;
        res              = '0;
        div_start        = 1'b0;

        if (cfg_we && (cfg_index == pqgs_pkg::REG_CAPACITY))
        begin
            cap_next = cfg_wdata;
        end
        if (cfg_we && (cfg_index == pqgs_pkg::REG_MARGIN))
        begin
            margin_next = cfg_wdata[15:0];
        end

        case (ctl.op)
            pqgs_pkg::OP_LOAD:
            begin
                cmd_next    = command;
                amt_next    = bit_amount;
                psize_next  = packet_size;
                tnow_next   = time_now;
                dly_next    = backhaul_delay;
                jit_next    = backhaul_jitter;
                budget_next = bit_amount;
                moved_next  = '0;
                n_next      = '0;
            end
            pqgs_pkg::OP_DIV_START:
            begin
                div_start = 1'b1;
            end
            pqgs_pkg::OP_GEN_SETUP:
            begin
                // packets = ceil(amount / size); the last holds the remainder, or a full size if none
                pkts_next  = div_q + {23'd0, div_r != '0};
                full_next  = (div_r != '0) ? div_q : div_q - 24'd1;
                lsize_next = (div_r != '0) ? div_r : psize_reg;
                i_next     = '0;
            end
            pqgs_pkg::OP_GEN_FULL:
            begin
                ent_we      = 1'b1;
                count_next  = count_reg + (AW + 1)'(1);
                queued_next = queued_reg + {8'd0, psize_reg};
                moved_next  = moved_reg + {8'd0, psize_reg};
                i_next      = i_reg + 24'd1;
            end
            pqgs_pkg::OP_GEN_LAST:
            begin
                ent_wdata.id   = next_id_reg + {8'd0, full_reg};
                ent_wdata.size = lsize_reg;
                if (app_ok_last)
                begin
                    ent_we      = 1'b1;
                    count_next  = count_reg + (AW + 1)'(1);
                    queued_next = queued_reg + {8'd0, lsize_reg};
                    moved_next  = moved_reg + {8'd0, lsize_reg};
                end
                next_id_next = next_id_reg + {8'd0, pkts_reg};
            end
            pqgs_pkg::OP_GEN_RESULT:
            begin
                buf_we    = 1'b1;
                res.kind  = pqgs_pkg::KIND_GEN;
                res.id    = next_id_reg;
                res.moved = moved_reg;
                n_next    = RCW'(1);
            end
            pqgs_pkg::OP_HEAD_READ:
            begin
                ent_re = 1'b1;
            end
            pqgs_pkg::OP_GRANT_EVAL:
            begin
                buf_we     = 1'b1;
                res.kind   = pqgs_pkg::KIND_PKT;
                res.id     = ent_rd.id;
                res.fcount = cnt_bumped;
                res.stamp  = ent_rd.stamp;
                res.delay  = ent_rd.delay;
                res.jitter = ent_rd.jitter;
                n_next     = n_reg + RCW'(1);
                if (whole)
                begin
                    res.bits    = ent_rd.size;
                    res.moved   = moved_reg + {8'd0, ent_rd.size};
                    moved_next  = moved_reg + {8'd0, ent_rd.size};
                    budget_next = budget_left;
                    head_next   = head_inc;
                    count_next  = count_reg - (AW + 1)'(1);
                end
                else
                begin
                    // split: fragment of the budget left, rest stays at the head
                    res.bits         = budget_reg[15:0];
                    res.fflag        = 1'b1;
                    res.moved        = moved_reg + budget_reg;
                    moved_next       = moved_reg + budget_reg;
                    budget_next      = '0;
                    ent_we           = 1'b1;
                    ent_waddr        = head_reg;
                    ent_wdata        = ent_rd;
                    ent_wdata.size   = ent_rd.size - budget_reg[15:0];
                    ent_wdata.fflag  = 1'b1;
                    ent_wdata.fcount = cnt_bumped;
                end
            end
            pqgs_pkg::OP_GRANT_END:
            begin
                queued_next = (queued_reg > moved_reg) ? queued_reg - moved_reg : '0;
                if (n_reg == '0)
                begin
                    buf_we   = 1'b1;
                    res.kind = pqgs_pkg::KIND_NONE;
                    n_next   = RCW'(1);
                end
            end
            pqgs_pkg::OP_POP_EVAL:
            begin
                buf_we      = 1'b1;
                res.kind    = pqgs_pkg::KIND_PKT;
                res.id      = ent_rd.id;
                res.bits    = ent_rd.size;
                res.fflag   = ent_rd.fflag;
                res.fcount  = ent_rd.fcount;
                res.stamp   = ent_rd.stamp;
                res.delay   = ent_rd.delay;
                res.jitter  = ent_rd.jitter;
                res.moved   = {8'd0, ent_rd.size};
                n_next      = RCW'(1);
                head_next   = head_inc;
                count_next  = count_reg - (AW + 1)'(1);
                queued_next = (queued_reg > {8'd0, ent_rd.size}) ?
                              queued_reg - {8'd0, ent_rd.size} : '0;
            end
            pqgs_pkg::OP_NONE_RESULT:
            begin
                buf_we   = 1'b1;
                res.kind = pqgs_pkg::KIND_NONE;
                n_next   = RCW'(1);
            end
            pqgs_pkg::OP_TICK:
            begin
                cur_time_next = tnow_reg;
                buf_we        = 1'b1;
                res.kind      = pqgs_pkg::KIND_TICKED;
                n_next        = RCW'(1);
            end
            pqgs_pkg::OP_OLDEST:
            begin
                oldest_next = (count_reg != '0) ? ent_rd.stamp : cur_time_reg;
                k_next      = '0;
            end
            pqgs_pkg::OP_BUF_READ:
            begin
                buf_re = 1'b1;
            end
            pqgs_pkg::OP_OUT_LOAD:
            begin
                out_res_next   = buf_rd;
                out_occ_next   = queued_reg;
                out_old_next   = oldest_reg;
                out_last_next  = (k_reg + RCW'(1)) == n_reg;
                out_valid_next = 1'b1;
                k_next         = k_reg + RCW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            queued_reg    <= '0;
            next_id_reg   <= '0;
            cur_time_reg  <= '0;
            cap_reg       <= pqgs_pkg::CAPACITY_RESET;
            margin_reg    <= pqgs_pkg::MARGIN_RESET;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            queued_reg    <= queued_next;
            next_id_reg   <= next_id_next;
            cur_time_reg  <= cur_time_next;
            cap_reg       <= cap_next;
            margin_reg    <= margin_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        amt_reg      <= amt_next;
        psize_reg    <= psize_next;
        tnow_reg     <= tnow_next;
        dly_reg      <= dly_next;
        jit_reg      <= jit_next;
        budget_reg   <= budget_next;
        moved_reg    <= moved_next;
        full_reg     <= full_next;
        pkts_reg     <= pkts_next;
        lsize_reg    <= lsize_next;
        i_reg        <= i_next;
        oldest_reg   <= oldest_next;
        out_res_reg  <= out_res_next;
        out_occ_reg  <= out_occ_next;
        out_old_reg  <= out_old_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_res_reg.kind;
    assign packet_id      = out_res_reg.id;
    assign packet_bits    = out_res_reg.bits;
    assign fragment_flag  = out_res_reg.fflag;
    assign fragment_count = out_res_reg.fcount;
    assign arrival_time   = out_res_reg.stamp;
    assign delay_out      = out_res_reg.delay;
    assign jitter_out     = out_res_reg.jitter;
    assign moved_bits     = out_res_reg.moved;
    assign occupancy      = out_occ_reg;
    assign oldest_time    = out_old_reg;
    assign last           = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above queue depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_SLOT)
        else $error("head pointer out of range");

    a_results_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_N)
        else $error("result count above buffer depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == pqgs_pkg::OP_OUT_LOAD) |-> (!out_valid_reg || out_ready))
        else $error("output register loaded while holding an item");

    a_empty_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == pqgs_pkg::OP_GEN_FULL) |=> (count_reg != '0))
        else $error("append left queue empty");
`endif

endmodule

// ----- hw/rtl/pqgs_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences datapath operations for each command.
// Depends on pqgs_pkg.
module pqgs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pqgs_pkg::st_t  st,
    output pqgs_pkg::ctl_t ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_GEN_CHK  = 4'd2;
    localparam logic [3:0] S_GEN_DIV  = 4'd3;
    localparam logic [3:0] S_GEN_FULL = 4'd4;
    localparam logic [3:0] S_GEN_RES  = 4'd5;
    localparam logic [3:0] S_GR_CHK   = 4'd6;
    localparam logic [3:0] S_GR_EVAL  = 4'd7;
    localparam logic [3:0] S_GR_END   = 4'd8;
    localparam logic [3:0] S_POP_CHK  = 4'd9;
    localparam logic [3:0] S_POP_EVAL = 4'd10;
    localparam logic [3:0] S_TICK     = 4'd11;
    localparam logic [3:0] S_OLD_REQ  = 4'd12;
    localparam logic [3:0] S_OLD_LAT  = 4'd13;
    localparam logic [3:0] S_EM_REQ   = 4'd14;
    localparam logic [3:0] S_EM_LOAD  = 4'd15;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = pqgs_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.op     = pqgs_pkg::OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (st.cmd)
                    pqgs_pkg::CMD_GEN:   state_next = S_GEN_CHK;
                    pqgs_pkg::CMD_GRANT: state_next = S_GR_CHK;
                    pqgs_pkg::CMD_POP:   state_next = S_POP_CHK;
                    default:             state_next = S_TICK;
                endcase
            end
            S_GEN_CHK:
            begin
                if (st.gen_ok)
                begin
                    ctl.op     = pqgs_pkg::OP_DIV_START;
                    state_next = S_GEN_DIV;
                end
                else
                begin
                    state_next = S_GEN_RES;
                end
            end
            S_GEN_DIV:
            begin
                if (st.div_done)
                begin
                    ctl.op     = pqgs_pkg::OP_GEN_SETUP;
                    state_next = S_GEN_FULL;
                end
            end
            S_GEN_FULL:
            begin
                // full-size packets until all are queued or one is refused, then the remainder packet
                if (st.full_more && st.app_ok)
                begin
                    ctl.op = pqgs_pkg::OP_GEN_FULL;
                end
                else
                begin
                    ctl.op     = pqgs_pkg::OP_GEN_LAST;
                    state_next = S_GEN_RES;
                end
            end
            S_GEN_RES:
            begin
                ctl.op     = pqgs_pkg::OP_GEN_RESULT;
                state_next = S_OLD_REQ;
            end
            S_GR_CHK:
            begin
                if (st.grant_go)
                begin
                    ctl.op     = pqgs_pkg::OP_HEAD_READ;
                    state_next = S_GR_EVAL;
                end
                else
                begin
                    state_next = S_GR_END;
                end
            end
            S_GR_EVAL:
            begin
                ctl.op     = pqgs_pkg::OP_GRANT_EVAL;
                state_next = st.grant_stop ? S_GR_END : S_GR_CHK;
            end
            S_GR_END:
            begin
                ctl.op     = pqgs_pkg::OP_GRANT_END;
                state_next = S_OLD_REQ;
            end
            S_POP_CHK:
            begin
                if (st.cnt_nz)
                begin
                    ctl.op     = pqgs_pkg::OP_HEAD_READ;
                    state_next = S_POP_EVAL;
                end
                else
                begin
                    ctl.op     = pqgs_pkg::OP_NONE_RESULT;
                    state_next = S_OLD_REQ;
                end
            end
            S_POP_EVAL:
            begin
                ctl.op     = pqgs_pkg::OP_POP_EVAL;
                state_next = S_OLD_REQ;
            end
            S_TICK:
            begin
                ctl.op     = pqgs_pkg::OP_TICK;
                state_next = S_OLD_REQ;
            end
            S_OLD_REQ:
            begin
                ctl.op     = pqgs_pkg::OP_HEAD_READ;
                state_next = S_OLD_LAT;
            end
            S_OLD_LAT:
            begin
                ctl.op     = pqgs_pkg::OP_OLDEST;
                state_next = S_EM_REQ;
            end
            S_EM_REQ:
            begin
                ctl.op     = pqgs_pkg::OP_BUF_READ;
                state_next = S_EM_LOAD;
            end
            S_EM_LOAD:
            begin
                if (st.out_free)
                begin
                    ctl.op     = pqgs_pkg::OP_OUT_LOAD;
                    state_next = st.em_last ? S_IDLE : S_EM_REQ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/packet_queue_grant_segmenter_top.sv -----
`timescale 1ns / 1ps
// Top level of the packet queue grant segmenter: controller plus datapath.
// Depends on pqgs_pkg, pqgs_ctrl, pqgs_datapath.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid, in_ready  | command, bit_amount, packet_size, time_now,
//           |                     | backhaul_delay, backhaul_jitter
//   out     | out_valid,out_ready | kind, packet_id, packet_bits, fragment_flag,
//           |                     | fragment_count, arrival_time, delay_out,
//           |                     | jitter_out, moved_bits, occupancy,
//           |                     | oldest_time, last
//   cfg     | cfg_we              | cfg_index, cfg_wdata
//
// One item at a time; in_ready is high only between items. An accepted generate
// waits on the divider, then queues its full-size packets one after another; a
// grant reads and evaluates the queue head for each delivered piece. Each item
// then reads out its results one by one, and takes longer while out_ready holds
// off. Results are buffered and sent once the item's final occupancy is known;
// the last result may wait in the output register while the next item is taken.
// Reset clears queue state; the entry store needs no clearing pass.
module packet_queue_grant_segmenter_top #(
    parameter int QUEUE_DEPTH = pqgs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [23:0] bit_amount,
    input  logic [15:0] packet_size,
    input  logic [31:0] time_now,
    input  logic [15:0] backhaul_delay,
    input  logic [15:0] backhaul_jitter,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] packet_id,
    output logic [15:0] packet_bits,
    output logic        fragment_flag,
    output logic [7:0]  fragment_count,
    output logic [31:0] arrival_time,
    output logic [15:0] delay_out,
    output logic [15:0] jitter_out,
    output logic [23:0] moved_bits,
    output logic [23:0] occupancy,
    output logic [31:0] oldest_time,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    pqgs_pkg::ctl_t ctl;
    pqgs_pkg::st_t  st;

    pqgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .ctl      (ctl)
    );

    pqgs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .st              (st),
        .command         (command),
        .bit_amount      (bit_amount),
        .packet_size     (packet_size),
        .time_now        (time_now),
        .backhaul_delay  (backhaul_delay),
        .backhaul_jitter (backhaul_jitter),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .packet_id       (packet_id),
        .packet_bits     (packet_bits),
        .fragment_flag   (fragment_flag),
        .fragment_count  (fragment_count),
        .arrival_time    (arrival_time),
        .delay_out       (delay_out),
        .jitter_out      (jitter_out),
        .moved_bits      (moved_bits),
        .occupancy       (occupancy),
        .oldest_time     (oldest_time),
        .last            (last),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

endmodule

// ----- sim/packet_queue_grant_segmenter_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for packet_queue_grant_segmenter_top: directed table, then random
// traffic checked against a behavioral queue model. Depends on pqgs_pkg and the block RTL.
module packet_queue_grant_segmenter_top_tb;

    localparam int DEPTH    = pqgs_pkg::QUEUE_DEPTH_DEF;
    localparam int WDOG_MAX = 20000;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [15:0] bits;
        logic        fflag;
        logic [7:0]  fcount;
        logic [31:0] stamp;
        logic [15:0] delay;
        logic [15:0] jitter;
        logic [23:0] moved;
        logic [23:0] occ;
        logic [31:0] oldest;
        logic        last;
    } pkt_res_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [23:0] amount;
        logic [15:0] psize;
        logic [31:0] tnow;
        logic [15:0] delay;
        logic [15:0] jitter;
        bit          has_exp;
        logic [1:0]  exp_kind;
        logic [23:0] exp_occ;
    } cmd_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [23:0] bit_amount;
    logic [15:0] packet_size;
    logic [31:0] time_now;
    logic [15:0] backhaul_delay;
    logic [15:0] backhaul_jitter;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [31:0] packet_id;
    logic [15:0] packet_bits;
    logic        fragment_flag;
    logic [7:0]  fragment_count;
    logic [31:0] arrival_time;
    logic [15:0] delay_out;
    logic [15:0] jitter_out;
    logic [23:0] moved_bits;
    logic [23:0] occupancy;
    logic [31:0] oldest_time;
    logic        last;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_wdata;

    packet_queue_grant_segmenter_top dut (.*);

    // model state
    logic [31:0] q_id     [DEPTH];
    logic [15:0] q_size   [DEPTH];
    logic [31:0] q_stamp  [DEPTH];
    logic [15:0] q_delay  [DEPTH];
    logic [15:0] q_jitter [DEPTH];
    logic [7:0]  q_fcount [DEPTH];
    logic        q_fflag  [DEPTH];
    int unsigned q_head, q_count;
    logic [23:0] q_bits;
    logic [31:0] q_next_id, q_now;
    logic [23:0] cap_bits;
    logic [15:0] margin;

    pkt_res_t    pending_results[$];
    cmd_row_t    table_rows[$];
    int          errors;
    int          send_idle_pct, recv_stall_pct;
    bit          hold_recv;
    int          quiet_cycles;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic pkt_res_t blank_res(logic [1:0] k);
        pkt_res_t r;
        r = '{default: '0};
        r.kind = k;
        return r;
    endfunction

    function automatic pkt_res_t slot_res(int unsigned s, logic [15:0] b, logic f,
                                          logic [7:0] c, logic [23:0] mv);
        pkt_res_t r;
        r = blank_res(pqgs_pkg::KIND_PKT);
        r.id = q_id[s]; r.bits = b; r.fflag = f; r.fcount = c;
        r.stamp = q_stamp[s]; r.delay = q_delay[s]; r.jitter = q_jitter[s];
        r.moved = mv;
        return r;
    endfunction

    function automatic bit queue_append(logic [31:0] id, logic [15:0] sz, logic [31:0] t,
                                        logic [15:0] d, logic [15:0] j);
        int unsigned s;
        if (q_count >= DEPTH) return 0;
        if ({8'd0, q_bits} + sz > {8'd0, cap_bits}) return 0;
        s = (q_head + q_count) % DEPTH;
        q_id[s] = id; q_size[s] = sz; q_stamp[s] = t; q_delay[s] = d; q_jitter[s] = j;
        q_fcount[s] = 0; q_fflag[s] = 0;
        q_count++;
        q_bits = q_bits + sz;
        return 1;
    endfunction

    function automatic logic [7:0] sat_inc(logic [7:0] c);
        return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    // computes the results of one command and advances the queue model
    function automatic void predict_queue(cmd_row_t c);
        pkt_res_t    res[$];
        logic [31:0] pkts, full, budget, moved, acc;
        logic [15:0] rem;
        logic [7:0]  cnt;
        logic [31:0] oldest;
        int unsigned s;
        case (c.cmd)
            pqgs_pkg::CMD_GEN:
            begin
                acc = 0;
                if (c.psize != 0 && c.amount != 0 && q_bits < cap_bits)
                begin
                    pkts = (32'(c.amount) + c.psize - 1) / c.psize;
                    full = pkts - 1;
                    rem  = 16'(32'(c.amount) - full * c.psize);
                    for (int i = 0; i < full; i++)
                    begin
                        if (!queue_append(q_next_id + i, c.psize, c.tnow, c.delay, c.jitter))
                            break;
                        acc += c.psize;
                    end
                    if (queue_append(q_next_id + full, rem, c.tnow, c.delay, c.jitter))
                        acc += rem;
                    q_next_id += pkts;
                end
                res.insert(res.size(), blank_res(pqgs_pkg::KIND_GEN));
                res[0].moved = 24'(acc);
                res[0].id = q_next_id;
            end
            pqgs_pkg::CMD_GRANT:
            begin
                budget = c.amount;
                moved = 0;
                while (budget > 0 && q_count > 0 && res.size() < pqgs_pkg::MAX_RESULTS)
                begin
                    s = q_head;
                    cnt = sat_inc(q_fcount[s]);
                    if (budget >= q_size[s])
                    begin
                        budget -= q_size[s];
                        moved += q_size[s];
                        res.insert(res.size(),
                                   slot_res(s, q_size[s], 1'b0, cnt, 24'(moved)));
                        q_head = (q_head + 1) % DEPTH;
                        q_count--;
                        if (budget <= margin) break;
                    end
                    else
                    begin
                        moved += budget;
                        res.insert(res.size(),
                                   slot_res(s, 16'(budget), 1'b1, cnt, 24'(moved)));
                        q_size[s] = q_size[s] - 16'(budget);
                        q_fcount[s] = cnt;
                        q_fflag[s] = 1;
                        budget = 0;
                    end
                end
                q_bits = (q_bits > moved) ? q_bits - 24'(moved) : 0;
                if (res.size() == 0) res.insert(0, blank_res(pqgs_pkg::KIND_NONE));
            end
            pqgs_pkg::CMD_POP:
            begin
                if (q_count > 0)
                begin
                    s = q_head;
                    res.insert(res.size(), slot_res(s, q_size[s], q_fflag[s], q_fcount[s],
                                                    24'(q_size[s])));
                    q_head = (q_head + 1) % DEPTH;
                    q_count--;
                    q_bits = (q_bits > q_size[s]) ? q_bits - q_size[s] : 0;
                end
                else
                    res.insert(0, blank_res(pqgs_pkg::KIND_NONE));
            end
            default:
            begin
                q_now = c.tnow;
                res.insert(0, blank_res(pqgs_pkg::KIND_TICKED));
            end
        endcase
        oldest = (q_count > 0) ? q_stamp[q_head] : q_now;
        foreach (res[k])
        begin
            res[k].occ = q_bits;
            res[k].oldest = oldest;
            res[k].last = (k == res.size() - 1);
            pending_results.insert(pending_results.size(), res[k]);
        end
    endfunction

    task automatic chk(string name, logic [31:0] e, logic [31:0] a);
        if (a !== e)
        begin
            $error("%s exp %0d got %0d", name, e, a);
            errors++;
        end
    endtask

    // nothing may be in flight here; the extra edge keeps cfg_we pulses apart
    task automatic cfg_write(logic [1:0] idx, logic [23:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == pqgs_pkg::REG_CAPACITY) cap_bits = val;
        else margin = val[15:0];
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic send_cmd(cmd_row_t c);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1; command <= c.cmd; bit_amount <= c.amount; packet_size <= c.psize;
        time_now <= c.tnow; backhaul_delay <= c.delay; backhaul_jitter <= c.jitter;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_queue(c);
        if (c.has_exp)
        begin
            // directed rows: kind and occupancy are known by hand
            if (pending_results[$].kind !== c.exp_kind ||
                pending_results[$].occ !== c.exp_occ)
            begin
                $error("directed row: expected kind %0d occ %0d, model %0d %0d",
                       c.exp_kind, c.exp_occ, pending_results[$].kind,
                       pending_results[$].occ);
                errors++;
            end
        end
    endtask

    function automatic cmd_row_t mk(logic [1:0] cmd, logic [23:0] a, logic [15:0] p,
                                    logic [31:0] t, logic [15:0] d, logic [15:0] j);
        cmd_row_t r;
        r = '{cmd: cmd, amount: a, psize: p, tnow: t, delay: d, jitter: j,
              has_exp: 0, exp_kind: 0, exp_occ: 0};
        return r;
    endfunction

    function automatic cmd_row_t mk_exp(cmd_row_t r, logic [1:0] k, logic [23:0] o);
        r.has_exp = 1; r.exp_kind = k; r.exp_occ = o;
        return r;
    endfunction

    function automatic cmd_row_t rand_cmd();
        cmd_row_t r;
        int sel;
        sel = $urandom_range(99);
        r = mk(pqgs_pkg::CMD_TICK, 24'($urandom), 16'($urandom), $urandom,
               16'($urandom), 16'($urandom));
        if (sel < 40)
        begin
            r.cmd = pqgs_pkg::CMD_GEN;
            r.amount = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(4000));
            r.psize = ($urandom_range(9) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(1500, 1));
            if ($urandom_range(29) == 0) r.psize = 0;
        end
        else if (sel < 80)
        begin
            r.cmd = pqgs_pkg::CMD_GRANT;
            r.amount = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(5000));
        end
        else if (sel < 92)
            r.cmd = pqgs_pkg::CMD_POP;
        return r;
    endfunction

    // output side
    always @(posedge clk)
    begin
        pkt_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item, kind %0d", kind);
                errors++;
            end
            else
            begin
                e = pending_results[0];
                pending_results.delete(0);
                chk("kind", 32'(e.kind), 32'(kind));
                chk("packet_id", e.id, packet_id);
                chk("packet_bits", 32'(e.bits), 32'(packet_bits));
                chk("fragment_flag", 32'(e.fflag), 32'(fragment_flag));
                chk("fragment_count", 32'(e.fcount), 32'(fragment_count));
                chk("arrival_time", e.stamp, arrival_time);
                chk("delay_out", 32'(e.delay), 32'(delay_out));
                chk("jitter_out", 32'(e.jitter), 32'(jitter_out));
                chk("moved_bits", 32'(e.moved), 32'(moved_bits));
                chk("occupancy", 32'(e.occ), 32'(occupancy));
                chk("oldest_time", e.oldest, oldest_time);
                chk("last", 32'(e.last), 32'(last));
            end
        end
        out_ready <= !hold_recv && !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end

    // watchdog: cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0; quiet_cycles = 0; hold_recv = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        in_valid = 0; command = pqgs_pkg::CMD_TICK; bit_amount = 0; packet_size = 0;
        time_now = 0; backhaul_delay = 0; backhaul_jitter = 0; out_ready = 0;
        cfg_we = 0; cfg_index = pqgs_pkg::REG_CAPACITY; cfg_wdata = 0;
        q_head = 0; q_count = 0; q_bits = 0; q_next_id = 0; q_now = 0;
        cap_bits = pqgs_pkg::CAPACITY_RESET; margin = pqgs_pkg::MARGIN_RESET;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table
        table_rows.insert(table_rows.size(), mk_exp(mk(pqgs_pkg::CMD_POP, 0, 1, 0, 0, 0),
                                                    pqgs_pkg::KIND_NONE, 0));
        table_rows.insert(table_rows.size(),
                          mk_exp(mk(pqgs_pkg::CMD_GRANT, 24'hFFFFFF, 1, 0, 0, 0),
                                 pqgs_pkg::KIND_NONE, 0));
        table_rows.insert(table_rows.size(),
                          mk_exp(mk(pqgs_pkg::CMD_TICK, 0, 0, 32'hFFFFFFFF, 0, 0),
                                 pqgs_pkg::KIND_TICKED, 0));
        table_rows.insert(table_rows.size(), mk_exp(mk(pqgs_pkg::CMD_GEN, 1000, 0, 5, 1, 1),
                                                    pqgs_pkg::KIND_GEN, 0));
        table_rows.insert(table_rows.size(), mk_exp(mk(pqgs_pkg::CMD_GEN, 0, 100, 5, 1, 1),
                                                    pqgs_pkg::KIND_GEN, 0));
        table_rows.insert(table_rows.size(),
                          mk_exp(mk(pqgs_pkg::CMD_GEN, 250, 100, 32'h12345678,
                                    16'hFFFF, 16'hFFFF), pqgs_pkg::KIND_GEN, 250));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_GRANT, 130, 0, 0, 0, 0));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_GRANT, 30, 0, 0, 0, 0));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_POP, 0, 0, 0, 0, 0));
        table_rows.insert(table_rows.size(),
                          mk(pqgs_pkg::CMD_GEN, 24'h00FFFF, 16'hFFFF, 0, 16'hAAAA, 16'h5555));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_GEN, 200, 1, 7, 2, 3));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_GRANT, 24'hFFFFFF, 0, 0, 0, 0));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_GRANT, 24'hFFFFFF, 0, 0, 0, 0));
        table_rows.insert(table_rows.size(),
                          mk(pqgs_pkg::CMD_GEN, 24'hFFFFFF, 16'h8000, 9, 0, 0));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_GEN, 5, 1, 9, 0, 0));
        table_rows.insert(table_rows.size(),
                          mk(pqgs_pkg::CMD_POP, 0, 16'hFFFF, 32'hFFFFFFFF, 0, 0));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_GRANT, 1, 0, 0, 0, 0));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_GRANT, 1, 0, 0, 0, 0));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_POP, 0, 0, 0, 0, 0));
        table_rows.insert(table_rows.size(), mk(pqgs_pkg::CMD_GRANT, 24'hFFFFFF, 0, 0, 0, 0));
        foreach (table_rows[i]) send_cmd(table_rows[i]);
        wait_drained();

        // small capacity and a margin: drops and early grant stops
        cfg_write(pqgs_pkg::REG_CAPACITY, 24'd3000);
        cfg_write(pqgs_pkg::REG_MARGIN, 24'd200);
        send_cmd(mk(pqgs_pkg::CMD_GEN, 5000, 700, 11, 4, 4));
        send_cmd(mk(pqgs_pkg::CMD_GEN, 100, 50, 12, 4, 4));
        send_cmd(mk(pqgs_pkg::CMD_GRANT, 1500, 0, 0, 0, 0));
        wait_drained();
        cfg_write(pqgs_pkg::REG_MARGIN, 24'h00FFFF);
        send_cmd(mk(pqgs_pkg::CMD_GRANT, 800, 0, 0, 0, 0));
        wait_drained();
        cfg_write(pqgs_pkg::REG_CAPACITY, 24'd0);
        send_cmd(mk(pqgs_pkg::CMD_GEN, 100, 10, 1, 1, 1));
        wait_drained();
        cfg_write(pqgs_pkg::REG_CAPACITY, 24'hFFFFFF);
        cfg_write(pqgs_pkg::REG_MARGIN, 24'd0);

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 47 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 47 : 0;
            if (ph == 3) begin send_idle_pct = 30; recv_stall_pct = 30; end
            if (ph == 2)
                fork
                    begin
                        hold_recv = 1;
                        repeat (600) @(posedge clk);
                        hold_recv = 0;
                    end
                join_none
            for (int i = 0; i < 22; i++) send_cmd(rand_cmd());
            wait_drained();
            if (ph == 1) cfg_write(pqgs_pkg::REG_MARGIN, 24'($urandom_range(300)));
            if (ph == 2) cfg_write(pqgs_pkg::REG_CAPACITY, 24'($urandom_range(60000, 2000)));
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        wait_drained();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
